// ===== rtl/sts_pkg.sv =====
// Shared codes, field widths and types of the sorted table search block.
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

	localparam int CmdWidth  = 2;
	localparam int WordWidth = 32;
	localparam int ModeWidth = 2;
	localparam int PosWidth  = 10;

	localparam logic [CmdWidth-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CmdWidth-1:0] CMD_APPEND = 2'd1;
	localparam logic [CmdWidth-1:0] CMD_SEARCH = 2'd2;

	localparam logic [ModeWidth-1:0] MODE_FIRST = 2'd1;
	localparam logic [ModeWidth-1:0] MODE_LAST  = 2'd2;

	typedef struct packed {
		logic                found;
		logic [PosWidth-1:0] position;
	} sts_result_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} sts_cmp_t;

endpackage

`default_nettype wire

// ===== rtl/sts_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/sts_cmp.sv =====
// Shared signed comparator that sets a table entry against the search key.
`timescale 1ns / 1ps
`default_nettype none

module sts_cmp #(
	parameter int WIDTH = 32
) (
	input  wire logic [WIDTH-1:0] probe,
	input  wire logic [WIDTH-1:0] key,
	output sts_pkg::sts_cmp_t     result
);

	import sts_pkg::*;

	always_comb begin
		result.eq = (probe == key);
		result.gt = ($signed(probe) > $signed(key));
	end

endmodule

`default_nettype wire

// ===== rtl/sts_ctrl.sv =====
// Command sequencer: table fill count, append writes and the bisection loop.
`timescale 1ns / 1ps
`default_nettype none

module sts_ctrl #(
	parameter int TABLE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [sts_pkg::CmdWidth-1:0]    cmd,
	input  wire logic [DATA_WIDTH-1:0]           word,
	input  wire logic [sts_pkg::ModeWidth-1:0]   match_mode,
	output logic                                 mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]       mem_waddr,
	output logic [$clog2(TABLE_DEPTH)-1:0]       mem_raddr,
	input  wire logic [DATA_WIDTH-1:0]           mem_rdata,
	input  wire logic                            out_free,
	output logic                                 res_load,
	output sts_pkg::sts_result_t                 res
);

	import sts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          lo_q;
	logic [CW-1:0]          hi_q;
	logic [CW-1:0]          mid_q;
	logic [DATA_WIDTH-1:0]  key_q;
	logic [ModeWidth-1:0]   mode_q;
	logic                   hit_q;
	logic [CW-1:0]          pos_q;

	logic [CW-1:0]          mid;
	logic [CW-1:0]          lo_nx;
	logic [CW-1:0]          hi_nx;
	logic                   stop_nx;
	logic [CW+PosWidth-1:0] pos_ext;
	sts_cmp_t               cmp;

	sts_cmp #(
		.WIDTH(DATA_WIDTH)
	) u_cmp (
		.probe (mem_rdata),
		.key   (key_q),
		.result(cmp)
	);

	assign mid       = lo_q + ((hi_q - ONE_C - lo_q) >> 1);
	assign mem_raddr = mid[AW-1:0];
	assign mem_waddr = count_q[AW-1:0];
	assign mem_we    = (state_q == ST_IDLE) && in_valid && (cmd == CMD_APPEND)
		&& (count_q < DEPTH_C);
	assign in_stall  = (state_q != ST_IDLE);
	assign res_load  = (state_q == ST_DONE) && out_free;
	assign pos_ext   = {{PosWidth{1'b0}}, pos_q};

	always_comb begin
		res.found    = hit_q;
		res.position = pos_ext[PosWidth-1:0];
	end

	always_comb begin
		lo_nx   = lo_q;
		hi_nx   = hi_q;
		stop_nx = 1'b0;
		if (cmp.eq) begin
			if (mode_q == MODE_FIRST) begin
				hi_nx = mid_q;
			end else if (mode_q == MODE_LAST) begin
				lo_nx = mid_q + ONE_C;
			end else begin
				stop_nx = 1'b1;
			end
		end else if (cmp.gt) begin
			hi_nx = mid_q;
		end else begin
			lo_nx = mid_q + ONE_C;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			mid_q   <= '0;
			key_q   <= '0;
			mode_q  <= '0;
			hit_q   <= 1'b0;
			pos_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (cmd)
							CMD_CLEAR: begin
								count_q <= '0;
							end
							CMD_APPEND: begin
								if (count_q < DEPTH_C) begin
									count_q <= count_q + ONE_C;
								end
							end
							CMD_SEARCH: begin
								key_q   <= word;
								mode_q  <= match_mode;
								lo_q    <= '0;
								hi_q    <= count_q;
								hit_q   <= 1'b0;
								pos_q   <= '0;
								state_q <= (count_q == '0) ? ST_DONE : ST_READ;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					mid_q   <= mid;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmp.eq) begin
						hit_q <= 1'b1;
						pos_q <= mid_q;
					end
					lo_q    <= lo_nx;
					hi_q    <= hi_nx;
					state_q <= (stop_nx || (lo_nx >= hi_nx)) ? ST_DONE : ST_READ;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_table_binary_search.sv =====
// Top level of the sorted table store with bisection search.
//
// The input channel carries a command, a data word and a match mode under
// in_valid and in_stall. A clear empties the table and an append writes the
// next entry; appends beyond the table depth are dropped. A search looks
// the key up by bisection and gives one transfer on the output channel
// (found, position) under out_valid and out_stall. Each probe reads the
// table RAM and then sets the entry against the key in the shared
// comparator; a search over n entries makes at most ceil(log2(n + 1))
// probes. An empty table answers without a probe. in_stall is high while
// a search is in progress. The result sits in an output register, so new
// commands are taken while it waits; a further search holds in its last
// cycle until the receiver takes the earlier result. Reset empties the
// table and drops any pending result; table contents need no clearing as
// only entries below the fill count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 1024,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [sts_pkg::CmdWidth-1:0]         cmd,
	input  wire logic signed [sts_pkg::WordWidth-1:0] data_word,
	input  wire logic [sts_pkg::ModeWidth-1:0]        match_mode,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      found,
	output logic [sts_pkg::PosWidth-1:0]              position
);

	import sts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [DATA_WIDTH+WordWidth-1:0] word_ext;
	logic [DATA_WIDTH-1:0]           word;
	logic                            mem_we;
	logic [AW-1:0]                   mem_waddr;
	logic [AW-1:0]                   mem_raddr;
	logic [DATA_WIDTH-1:0]           mem_rdata;
	logic                            out_free;
	logic                            res_load;
	sts_result_t                     res;
	logic                            out_valid_q;
	sts_result_t                     result_q;

	assign word_ext = {{DATA_WIDTH{data_word[WordWidth-1]}}, data_word};
	assign word     = word_ext[DATA_WIDTH-1:0];
	assign out_free = !out_valid_q || !out_stall;

	sts_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(word),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	sts_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.word      (word),
		.match_mode(match_mode),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = result_q.found;
	assign position  = result_q.position;

endmodule

`default_nettype wire

// ===== rtl/sts_checker.sv =====
// Port-level assertions for the sorted table search block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sts_props (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic [sts_pkg::CmdWidth-1:0]       cmd,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic                               found,
	input wire logic [sts_pkg::PosWidth-1:0]       position
);

	import sts_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(position))
	else $error("stalled result changed or vanished");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> position == '0)
	else $error("result without a match carries a non-zero position");

	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd != CMD_SEARCH |=> !in_stall)
	else $error("clear or append transfer did not complete in one cycle");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_SEARCH |=> in_stall)
	else $error("search transfer did not hold the input channel");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
	else $error("result appeared without a search in progress");

endmodule

bind sorted_table_binary_search sts_props u_sts_props (.*);

`default_nettype wire
